// ----- hdl/morris_pratt_matcher_unit_defines.svh -----
// Assertion macros for the Morris-Pratt matcher.
// MPM_ASSERT checks a property while out of reset.
// MPM_ASSERT_ANY checks a property at every clock edge, reset included.
`ifndef MORRIS_PRATT_MATCHER_UNIT_DEFINES_SVH
`define MORRIS_PRATT_MATCHER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define MPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPM_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPM_ASSERT(lbl, prop, msg)
`define MPM_ASSERT_ANY(lbl, prop, msg)
`endif

`endif

// ----- hdl/mpm_pkg.sv -----
package mpm_pkg;

    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int START_W  = 32;
    localparam int OUSER_W  = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_POST = 4'b1000
    } state_t;

endpackage

// ----- hdl/morris_pratt_matcher_unit.sv -----
// Streaming Morris-Pratt matcher.
// Input channel s_*: s_tuser carries the command (clear, append pattern
// byte, text byte), s_tdata the byte. Output channel m_*: one result item
// per input item, m_tuser = {status, match}, m_tdata = match start index.
// One item is worked on at a time; s_tready is high only while idle.
// Clear, unused commands, refused appends, appends to an empty pattern and
// text bytes on an empty pattern skip the walk: the result is set at accept,
// and s_tready returns when it moves into the output register. Other
// appends and text bytes walk the failure chain through the pattern/failure
// memories: each link is a registered memory read, then a compare, and
// k links are visited, k from 1 to the pattern length. Amortized over a
// text stream this is about 2 links per byte.
// The result sits in an output register; the next item is accepted while
// it waits, and the block holds its next result until m_tready frees the
// slot. Reset empties the pattern, zeroes the text position and drops any
// pending result; the memories are not cleared, since only entries below
// the current pattern length are ever read.
module morris_pratt_matcher_unit #(
    parameter int MAX_PATTERN = 64,
    parameter int POS_BITS    = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mpm_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    input  logic [mpm_pkg::CMD_W-1:0]     s_tuser,   // [1:0] cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mpm_pkg::START_W-1:0]   m_tdata,   // [31:0] match_start
    output logic [mpm_pkg::OUSER_W-1:0]   m_tuser    // [0] match, [1] status
);

`include "morris_pratt_matcher_unit_defines.svh"

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0]    MAX_LEN = LEN_W'(MAX_PATTERN);
    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    mpm_pkg::state_t state_reg, state_next;

    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    pw_reg, pw_next;
    logic [LEN_W-1:0]    ml_reg, ml_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic [mpm_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [mpm_pkg::BYTE_W-1:0]  byte_reg, byte_next;
    logic [LEN_W-1:0]            walk_reg, walk_next;
    logic                        rmatch_reg, rmatch_next;
    logic                        rstatus_reg, rstatus_next;
    logic [mpm_pkg::START_W-1:0] rstart_reg, rstart_next;
    logic [mpm_pkg::START_W-1:0] m_tdata_reg, m_tdata_next;
    logic [mpm_pkg::OUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic                        wr_en;
    logic [mpm_pkg::BYTE_W-1:0]  rd_byte;
    logic [LEN_W-1:0]            rd_fail;
    logic                        hit;
    logic [LEN_W-1:0]            ext_len;
    logic [POS_BITS-1:0]         start_pos;

    mpm_store #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (len_reg),
        .wr_byte (byte_reg),
        .wr_fail (walk_reg),
        .rd_addr (walk_reg),
        .rd_byte (rd_byte),
        .rd_fail (rd_fail)
    );

    assign s_tready  = (state_reg == mpm_pkg::ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign hit       = (rd_byte == byte_reg);
    assign ext_len   = hit ? (walk_reg + LEN_W'(1)) : walk_reg;
    assign start_pos = pos_reg - POS_BITS'(len_reg) + POS_ONE;

    always_comb
    begin
        state_next    = state_reg;
        len_next      = len_reg;
        pw_next       = pw_reg;
        ml_next       = ml_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd_next      = cmd_reg;
        byte_next     = byte_reg;
        walk_next     = walk_reg;
        rmatch_next   = rmatch_reg;
        rstatus_next  = rstatus_reg;
        rstart_next   = rstart_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        wr_en         = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            mpm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next     = s_tuser;
                    byte_next    = s_tdata;
                    rmatch_next  = 1'b0;
                    rstatus_next = 1'b0;
                    rstart_next  = '0;
                    walk_next    = '0;
                    state_next   = mpm_pkg::ST_POST;
                    unique case (s_tuser)
                        mpm_pkg::CMD_CLEAR:
                        begin
                            len_next = '0;
                            pw_next  = '0;
                            ml_next  = '0;
                            pos_next = '0;
                        end
                        mpm_pkg::CMD_APPEND:
                        begin
                            if (len_reg == MAX_LEN)
                            begin
                                rstatus_next = 1'b1;
                            end
                            else if (len_reg != '0)
                            begin
                                walk_next  = pw_reg;
                                state_next = mpm_pkg::ST_RD;
                            end
                        end
                        mpm_pkg::CMD_TEXT:
                        begin
                            if (len_reg == '0)
                            begin
                                pos_next = pos_reg + POS_ONE;
                            end
                            else
                            begin
                                walk_next  = (ml_reg < len_reg) ? ml_reg : '0;
                                state_next = mpm_pkg::ST_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // memory read of the current link is in flight
            mpm_pkg::ST_RD:
            begin
                state_next = mpm_pkg::ST_CMP;
            end

            mpm_pkg::ST_CMP:
            begin
                if (walk_reg != '0 && !hit)
                begin
                    // follow the failure link
                    walk_next  = (rd_fail < walk_reg) ? rd_fail : '0;
                    state_next = mpm_pkg::ST_RD;
                end
                else
                begin
                    state_next = mpm_pkg::ST_POST;
                    if (cmd_reg == mpm_pkg::CMD_APPEND)
                    begin
                        walk_next = ext_len;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_ONE;
                        if (ext_len == len_reg)
                        begin
                            // full occurrence: continue from the border of the pattern
                            rmatch_next = 1'b1;
                            rstart_next = mpm_pkg::START_W'(start_pos);
                            ml_next     = pw_reg;
                        end
                        else
                        begin
                            ml_next = ext_len;
                        end
                    end
                end
            end

            mpm_pkg::ST_POST:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = rstart_reg;
                    m_tuser_next  = {rstatus_reg, rmatch_reg};
                    state_next    = mpm_pkg::ST_IDLE;
                    if (cmd_reg == mpm_pkg::CMD_APPEND && !rstatus_reg)
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + LEN_W'(1);
                        pw_next  = walk_reg;
                    end
                end
            end

            default:
            begin
                state_next = mpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mpm_pkg::ST_IDLE;
            len_reg      <= '0;
            pw_reg       <= '0;
            ml_reg       <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            pw_reg       <= pw_next;
            ml_reg       <= ml_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        byte_reg    <= byte_next;
        walk_reg    <= walk_next;
        rmatch_reg  <= rmatch_next;
        rstatus_reg <= rstatus_next;
        rstart_reg  <= rstart_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    `MPM_ASSERT(a_len_bound, (len_reg <= MAX_LEN), "pattern length beyond capacity")
    `MPM_ASSERT(a_border_short, (len_reg == '0) ? (pw_reg == '0) : (pw_reg < len_reg), "pattern border not shorter than pattern")
    `MPM_ASSERT(a_match_short, (ml_reg == '0) || (ml_reg < len_reg), "partial match not shorter than pattern")
    `MPM_ASSERT(a_walk_in_range, (state_reg == mpm_pkg::ST_RD) |-> (walk_reg < len_reg), "failure walk outside the pattern")
    `MPM_ASSERT(a_busy_drops_post, (state_reg == mpm_pkg::ST_POST && m_tvalid_reg && !m_tready) |=> (state_reg == mpm_pkg::ST_POST), "result left while output slot was full")

endmodule

// ----- hdl/mpm_store.sv -----
module mpm_store #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]  wr_addr,
    input  logic [mpm_pkg::BYTE_W-1:0]        wr_byte,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]  wr_fail,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]  rd_addr,
    output logic [mpm_pkg::BYTE_W-1:0]        rd_byte,
    output logic [$clog2(MAX_PATTERN+1)-1:0]  rd_fail
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [mpm_pkg::BYTE_W-1:0] pat_mem  [MAX_PATTERN];
    logic [LEN_W-1:0]           fail_mem [MAX_PATTERN+1];

    // pattern byte goes to slot m, border of the new prefix to slot m+1
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pat_mem[wr_addr[ADDR_W-1:0]] <= wr_byte;
            fail_mem[wr_addr + LEN_W'(1)] <= wr_fail;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_byte <= pat_mem[rd_addr[ADDR_W-1:0]];
        rd_fail <= fail_mem[rd_addr];
    end

endmodule

// ----- dv/tb_morris_pratt_matcher_unit.sv -----
module tb_morris_pratt_matcher_unit;

    localparam int MAX_PAT      = 64;
    localparam int ITEM_TARGET  = 1450;
    // longest item: a walk over every failure link, plus margin
    localparam int DRAIN_CYCLES = 2 + 2 * (MAX_PAT + 1) + 16;
    localparam logic [mpm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic                        hit;
        logic [mpm_pkg::START_W-1:0] start_idx;
        logic                        refused;
    } match_result_t;

    logic                         clk;
    logic                         rst_n    = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [mpm_pkg::BYTE_W-1:0]   s_tdata  = '0;   // [7:0] data_byte
    logic [mpm_pkg::CMD_W-1:0]    s_tuser  = '0;   // [1:0] cmd
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [mpm_pkg::START_W-1:0]  m_tdata;         // [31:0] match_start
    logic [mpm_pkg::OUSER_W-1:0]  m_tuser;         // [0] match, [1] status

    // matcher state mirrored by the predictor
    bit [7:0]                     pat_mem [MAX_PAT];
    bit [6:0]                     border_tab [MAX_PAT + 1];
    int unsigned                  pat_len;
    int unsigned                  whole_border;
    int unsigned                  matched;
    logic [mpm_pkg::START_W-1:0]  text_idx;

    match_result_t       pending_results [$];
    int                  err_count;
    int                  items_sent;
    int                  results_seen;
    int                  match_count;
    int                  refusal_count;
    int                  out_wait;
    bit                  steady_flow;

    morris_pratt_matcher_unit #(
        .MAX_PATTERN (MAX_PAT),
        .POS_BITS    (mpm_pkg::START_W)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int draw_wait();
        return steady_flow ? 0 : $urandom_range(0, 7);
    endfunction

    // Extend border length b by byte c, falling back along the failure links.
    function automatic int unsigned follow_links(int unsigned b, bit [7:0] c);
        while (b > 0 && pat_mem[b] != c)
            b = border_tab[b];
        if (pat_mem[b] == c)
            b++;
        return b;
    endfunction

    function automatic match_result_t step_matcher(logic [mpm_pkg::CMD_W-1:0] cmd, bit [7:0] c);
        match_result_t r;
        int unsigned   b;
        int unsigned   j;
        r = '0;
        case (cmd)
            mpm_pkg::CMD_CLEAR:
            begin
                pat_len      = 0;
                whole_border = 0;
                matched      = 0;
                text_idx     = '0;
            end
            mpm_pkg::CMD_APPEND:
            begin
                if (pat_len >= MAX_PAT)
                    r.refused = 1'b1;
                else
                begin
                    b = (pat_len == 0) ? 0 : follow_links(whole_border, c);
                    pat_mem[pat_len]        = c;
                    border_tab[pat_len + 1] = 7'(b);
                    whole_border            = b;
                    pat_len++;
                end
            end
            mpm_pkg::CMD_TEXT:
            begin
                if (pat_len > 0)
                begin
                    j = (matched < pat_len) ? matched : 0;
                    j = follow_links(j, c);
                    if (j >= pat_len)
                    begin
                        r.hit       = 1'b1;
                        r.start_idx = text_idx - mpm_pkg::START_W'(pat_len - 1);
                        j           = border_tab[pat_len];
                    end
                    matched = j;
                end
                text_idx = text_idx + 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_item(logic [mpm_pkg::CMD_W-1:0] cmd, logic [7:0] data);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(step_matcher(cmd, data));
        items_sent++;
    endtask

    task automatic check_result();
        match_result_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            $display("%0t: result with nothing expected: expected none, actual tdata %h tuser %b",
                     $time, m_tdata, m_tuser);
            err_count++;
            return;
        end
        want = pending_results.pop_front();
        if (want.hit)
            match_count++;
        if (want.refused)
            refusal_count++;
        if (m_tuser[0] !== want.hit)
        begin
            $display("%0t: match mismatch: expected %b, actual %b", $time, want.hit, m_tuser[0]);
            err_count++;
        end
        if (m_tdata !== want.start_idx)
        begin
            $display("%0t: match_start mismatch: expected %h, actual %h",
                     $time, want.start_idx, m_tdata);
            err_count++;
        end
        if (m_tuser[1] !== want.refused)
        begin
            $display("%0t: status mismatch: expected %b, actual %b",
                     $time, want.refused, m_tuser[1]);
            err_count++;
        end
    endtask

    // Result side: check each item, then hold tready low for a drawn number of cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_result();
                out_wait = draw_wait();
            end
            if (out_wait > 0)
            begin
                m_tready <= 1'b0;
                out_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        steady_flow = 1'b0;
        send_item(mpm_pkg::CMD_TEXT, 8'h41);      // empty pattern after reset
        send_item(mpm_pkg::CMD_CLEAR, 8'hFF);
        send_item(mpm_pkg::CMD_APPEND, 8'h00);
        send_item(mpm_pkg::CMD_APPEND, 8'hFF);
        send_item(mpm_pkg::CMD_APPEND, 8'h00);
        send_item(mpm_pkg::CMD_TEXT, 8'h00);
        send_item(mpm_pkg::CMD_TEXT, 8'hFF);
        send_item(mpm_pkg::CMD_TEXT, 8'h00);
        send_item(mpm_pkg::CMD_TEXT, 8'hFF);
        send_item(mpm_pkg::CMD_TEXT, 8'h00);      // overlapping occurrence
        send_item(CMD_UNUSED, 8'hA5);
        send_item(mpm_pkg::CMD_APPEND, 8'hFF);    // grow the pattern mid-text
        send_item(mpm_pkg::CMD_TEXT, 8'hFF);
        send_item(mpm_pkg::CMD_TEXT, 8'h00);
        send_item(mpm_pkg::CMD_TEXT, 8'hFF);
        send_item(mpm_pkg::CMD_CLEAR, 8'h00);
        send_item(mpm_pkg::CMD_TEXT, 8'h55);
        send_item(mpm_pkg::CMD_APPEND, 8'h55);
        send_item(mpm_pkg::CMD_TEXT, 8'h55);
        send_item(mpm_pkg::CMD_TEXT, 8'h55);
        send_item(mpm_pkg::CMD_TEXT, 8'hAA);
        send_item(CMD_UNUSED, 8'h5A);
    endtask

    task automatic test_store_full();
        steady_flow = 1'b0;
        send_item(mpm_pkg::CMD_CLEAR, 8'h3C);
        // a run of one byte gives the longest failure chains
        repeat (MAX_PAT) send_item(mpm_pkg::CMD_APPEND, 8'h61);
        send_item(mpm_pkg::CMD_APPEND, 8'h61);
        send_item(mpm_pkg::CMD_APPEND, 8'hC3);
        send_item(CMD_UNUSED, 8'hFF);
        repeat (MAX_PAT + 6) send_item(mpm_pkg::CMD_TEXT, 8'h61);
        send_item(mpm_pkg::CMD_TEXT, 8'h62);
        send_item(mpm_pkg::CMD_TEXT, 8'h61);
    endtask

    task automatic test_random_sequences();
        int         roll;
        int         span;
        int         pat_cnt;
        int         txt_cnt;
        int         noise;
        logic [7:0] base;
        while (items_sent < ITEM_TARGET)
        begin
            steady_flow = ($urandom_range(0, 4) == 0);
            base = 8'($urandom_range(0, 255));
            roll = $urandom_range(0, 9);
            span = (roll < 2) ? 256 : ((roll == 2) ? 1 : $urandom_range(2, 3));
            roll = $urandom_range(0, 19);
            pat_cnt = (roll == 0) ? $urandom_range(60, 66)
                    : ((roll < 3) ? $urandom_range(7, 20) : $urandom_range(1, 6));
            txt_cnt = $urandom_range(8, 40);
            // sometimes keep the old pattern and extend it
            if ($urandom_range(0, 7) != 0)
                send_item(mpm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
            repeat (pat_cnt)
                send_item(mpm_pkg::CMD_APPEND, 8'(base + $urandom_range(0, span - 1)));
            repeat (txt_cnt)
            begin
                noise = $urandom_range(0, 99);
                if (noise == 0)
                    send_item(CMD_UNUSED, 8'($urandom_range(0, 255)));
                else if (noise == 1)
                    send_item(mpm_pkg::CMD_APPEND, 8'(base + $urandom_range(0, span - 1)));
                else if (noise == 2)
                    send_item(mpm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
                else
                    send_item(mpm_pkg::CMD_TEXT, 8'(base + $urandom_range(0, span - 1)));
            end
        end
    endtask

    initial
    begin
        pat_len      = 0;
        whole_border = 0;
        matched      = 0;
        text_idx     = '0;
        out_wait     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_store_full();
        test_random_sequences();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            err_count++;
        end
        $display("Sent %0d items (clear, append, text, unused) and checked %0d results.",
                 items_sent, results_seen);
        $display("Saw %0d matches and %0d refused appends on a full pattern store.",
                 match_count, refusal_count);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
